// ===== rtl/qaip_pkg.sv =====
// ----------------------------------------------------------------------------
// qaip_pkg
// Shared constants for the quadrature angle PID controller: register
// indexes, item modes, reset values and default parameter values.
// ----------------------------------------------------------------------------
package qaip_pkg;

	// default parameter values
	localparam int COUNT_WIDTH_DEF   = 24;
	localparam int DUTY_MAX_DEF      = 100;
	localparam int FRACTION_BITS_DEF = 8;

	// gain format is Q8.8
	localparam int GAIN_FRAC = 8;

	// item modes
	localparam logic [1:0] MODE_EDGE_A = 2'd0;
	localparam logic [1:0] MODE_EDGE_B = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [2:0] REG_TARGET_ANGLE  = 3'd3;
	localparam logic [2:0] REG_DEG_PER_COUNT = 3'd4;

	// reset values: 360.0 degrees in Q16.8, about 360/3360 in Q0.16
	localparam logic [23:0] TARGET_ANGLE_RST = 24'd92160;
	localparam logic [15:0] DEG_PER_COUNT_RST = 16'd7022;

	// angle saturation bound
	localparam logic [23:0] ANGLE_MAX = 24'hFFFFFF;

endpackage

// ===== rtl/quadrature_angle_incremental_pid.sv =====
// Edge beats (mode A or B) step the saturating position count. A control
// tick occupies the block from acceptance through the sequencer states
// S_ANG_MUL to S_DONE (S_ERR to S_SUM are skipped once the controller has
// stopped): one signed multiplier of max(COUNT_WIDTH+1,27) by 17 bits is
// used in turn for the angle product and for the proportional, integral and
// derivative products. The result beat sits in an output register; while it
// waits, edge beats and the work of the next tick go on, and only the final
// step of a tick waits for the output register to free.
// Mode 3 beats are taken and dropped. Configuration writes are always ready.
// ----------------------------------------------------------------------------
// quadrature_angle_incremental_pid
// Quadrature position counter feeding a velocity-form PID loop that drives a
// motor forward until a target angle is reached, then stops for good.
// ----------------------------------------------------------------------------
module quadrature_angle_incremental_pid
	import qaip_pkg::*;
#(
	parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
	parameter int DUTY_MAX      = DUTY_MAX_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic               level_a,
	input  logic               level_b,
	// result items
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         duty,
	output logic               drive_on,
	output logic               stopped,
	output logic [23:0]        angle,
	output logic signed [31:0] control_value,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// widths
	localparam int E_W    = 25;                      // error: target - angle
	localparam int D1_W   = E_W + 1;                 // first difference
	localparam int D2_W   = E_W + 2;                 // second difference
	localparam int MA_W   = (COUNT_WIDTH + 1 > D2_W) ? COUNT_WIDTH + 1 : D2_W;
	localparam int MB_W   = 17;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int ACC_W  = SUM_W + 1;
	localparam int ANG_W  = COUNT_WIDTH + 16;
	localparam int ASH    = 16 - FRACTION_BITS;

	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [ANG_W-1:0] ANG_SAT = ANG_W'(ANGLE_MAX);
	localparam logic [31:0] DUTY_LIM = 32'(DUTY_MAX);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ANG_MUL,
		S_ANG_SAT,
		S_ERR,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_SUM,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [15:0] prop_gain_q, integral_gain_q, deriv_gain_q;
	logic [23:0]        target_q;
	logic [15:0]        dpc_q;

	// controller state
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic signed [E_W-1:0]         e_q, e1_q, e2_q;
	logic signed [31:0]            acc_q;
	logic                          halted_q;

	// datapath registers
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [23:0]              angle_q;

	// output register
	logic                     out_valid_q;
	logic [6:0]               duty_q;
	logic                     drive_q, stopped_q;
	logic [23:0]              angle_out_q;
	logic signed [31:0]       ctrl_q;

	// combinational
	logic                     in_acc, same, up;
	logic [COUNT_WIDTH-1:0]   mag;
	logic signed [D1_W-1:0]   d1;
	logic signed [D2_W-1:0]   d2;
	logic signed [E_W-1:0]    e_new;
	logic signed [MA_W-1:0]   op_a;
	logic signed [MB_W-1:0]   op_b;
	logic signed [PROD_W-1:0] prod;
	logic [ANG_W-1:0]         ang_full;
	logic [23:0]              ang_sat;
	logic signed [SUM_W-1:0]  prod_ext, delta;
	logic signed [ACC_W-1:0]  acc_wide;
	logic signed [31:0]       acc_sat, acc_new;
	logic [31:0]              acc_mag, duty_full, duty_sel;
	logic                     halt_now, out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// encoder direction
	assign same = (level_a == level_b);
	assign up   = (mode == MODE_EDGE_A) ? !same : same;

	// count magnitude, most negative count maps to 2^(COUNT_WIDTH-1)
	assign mag = count_q[COUNT_WIDTH-1] ? (~count_q + 1'b1) : count_q;

	// error and its differences
	assign e_new = {1'b0, target_q} - {1'b0, angle_q};
	assign d1    = {e_q[E_W-1], e_q} - {e1_q[E_W-1], e1_q};
	assign d2    = {{2{e_q[E_W-1]}}, e_q} - {e1_q[E_W-1], e1_q, 1'b0}
	             + {{2{e2_q[E_W-1]}}, e2_q};

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_ANG_MUL: begin
				op_a = {{(MA_W-COUNT_WIDTH){1'b0}}, mag};
				op_b = {1'b0, dpc_q};
			end
			S_MUL_P: begin
				op_a = {{(MA_W-D1_W){d1[D1_W-1]}}, d1};
				op_b = {prop_gain_q[15], prop_gain_q};
			end
			S_MUL_I: begin
				op_a = {{(MA_W-E_W){e_q[E_W-1]}}, e_q};
				op_b = {integral_gain_q[15], integral_gain_q};
			end
			S_MUL_D: begin
				op_a = {{(MA_W-D2_W){d2[D2_W-1]}}, d2};
				op_b = {deriv_gain_q[15], deriv_gain_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// angle scaling and saturation
	assign ang_full = prod_q[ANG_W-1:0] >> ASH;
	assign ang_sat  = (ang_full > ANG_SAT) ? ANGLE_MAX : ang_full[23:0];

	// delta with floor shift, saturating accumulate
	assign prod_ext = {{2{prod_q[PROD_W-1]}}, prod_q};
	assign delta    = sum_q >>> GAIN_FRAC;
	assign acc_wide = {{(ACC_W-32){acc_q[31]}}, acc_q} + {delta[SUM_W-1], delta};

	always_comb begin
		if (&acc_wide[ACC_W-1:31] || ~|acc_wide[ACC_W-1:31]) begin
			acc_sat = acc_wide[31:0];
		end else if (acc_wide[ACC_W-1]) begin
			acc_sat = 32'sh8000_0000;
		end else begin
			acc_sat = 32'sh7FFF_FFFF;
		end
	end

	assign acc_new  = halted_q ? acc_q : acc_sat;
	assign halt_now = halted_q || (angle_q >= target_q);

	// duty from accumulator magnitude
	assign acc_mag   = acc_new[31] ? (~acc_new + 1'b1) : acc_new;
	assign duty_full = acc_mag >> FRACTION_BITS;
	assign duty_sel  = (duty_full > DUTY_LIM) ? DUTY_LIM : duty_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= '0;
			integral_gain_q <= '0;
			deriv_gain_q    <= '0;
			target_q        <= TARGET_ANGLE_RST;
			dpc_q           <= DEG_PER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:     prop_gain_q     <= cfg_data[15:0];
				REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data[15:0];
				REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data[15:0];
				REG_TARGET_ANGLE:  target_q        <= cfg_data[23:0];
				REG_DEG_PER_COUNT: dpc_q           <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			e_q         <= '0;
			e1_q        <= '0;
			e2_q        <= '0;
			acc_q       <= '0;
			halted_q    <= 1'b0;
			prod_q      <= '0;
			sum_q       <= '0;
			angle_q     <= '0;
			out_valid_q <= 1'b0;
			duty_q      <= '0;
			drive_q     <= 1'b0;
			stopped_q   <= 1'b0;
			angle_out_q <= '0;
			ctrl_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (mode)
							MODE_EDGE_A, MODE_EDGE_B: begin
								if (up) begin
									if (count_q != CNT_MAX) count_q <= count_q + 1'b1;
								end else begin
									if (count_q != CNT_MIN) count_q <= count_q - 1'b1;
								end
							end
							MODE_TICK: state_q <= S_ANG_MUL;
							default: ;
						endcase
					end
				end
				S_ANG_MUL: begin
					prod_q  <= prod;
					state_q <= S_ANG_SAT;
				end
				S_ANG_SAT: begin
					angle_q <= ang_sat;
					state_q <= halted_q ? S_DONE : S_ERR;
				end
				S_ERR: begin
					e_q     <= e_new;
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					prod_q  <= prod;
					state_q <= S_MUL_I;
				end
				S_MUL_I: begin
					sum_q   <= prod_ext;
					prod_q  <= prod;
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					sum_q   <= sum_q + prod_ext;
					prod_q  <= prod;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q   <= sum_q + prod_ext;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						if (!halted_q) begin
							acc_q    <= acc_sat;
							e2_q     <= e1_q;
							e1_q     <= e_q;
							halted_q <= halt_now;
						end
						out_valid_q <= 1'b1;
						duty_q      <= halt_now ? 7'd0 : duty_sel[6:0];
						drive_q     <= !halt_now;
						stopped_q   <= halt_now;
						angle_out_q <= angle_q;
						ctrl_q      <= acc_new;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign duty          = duty_q;
	assign drive_on      = drive_q;
	assign stopped       = stopped_q;
	assign angle         = angle_out_q;
	assign control_value = ctrl_q;

endmodule

// ===== rtl/qaip_checker.sv =====
// ----------------------------------------------------------------------------
// qaip_checker
// Port-level checks for the quadrature angle PID controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module qaip_checker
	import qaip_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         mode,
	input logic               out_valid,
	input logic               out_stall,
	input logic [6:0]         duty,
	input logic               drive_on,
	input logic               stopped,
	input logic signed [31:0] control_value
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its control value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(control_value))
		else $error("control value changed while stalled");

	// a stopped result never drives the motor
	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped |-> duty == 7'd0 && !drive_on)
		else $error("stopped result drives the motor");

	// drive is on exactly when not stopped
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_on != stopped)
		else $error("drive and stop flags disagree");

	// an accepted tick keeps the input side busy next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_TICK |=> in_stall)
		else $error("input not busy after a control tick");

endmodule

bind quadrature_angle_incremental_pid qaip_checker u_qaip_checker (.*);

// ===== dv/tb_quadrature_angle_incremental_pid.sv =====
// ----------------------------------------------------------------------------
// tb_quadrature_angle_incremental_pid
// Self-checking bench for the quadrature angle PID controller. A directed
// table covers reset values, both count directions on each channel, the
// unused mode, ignored register indexes and gain extremes. Random phases then
// play well-formed encoder runs mixed with control ticks and junk beats, under
// several sender and receiver idling patterns and one long receiver hold-off.
// Each result beat is checked field by field against an in-bench model of the
// encoder count and the incremental PID loop, or against a typed table row.
// ----------------------------------------------------------------------------
module tb_quadrature_angle_incremental_pid
	import qaip_pkg::*;
;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 215;
	localparam int DIR_ROWS      = 32;

	// codes the block ignores
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] REG_SPARE_5 = 3'd5;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	localparam logic signed [23:0] COUNT_TOP    = 24'sh7FFFFF;
	localparam logic signed [23:0] COUNT_BOTTOM = 24'h800000;
	localparam longint ACC_TOP    = 64'sd2147483647;
	localparam longint ACC_BOTTOM = -64'sd2147483648;

	typedef struct packed {
		logic [6:0]         duty;
		logic               drive_on;
		logic               stopped;
		logic [23:0]        angle;
		logic signed [31:0] control;
	} pid_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  mode;
		logic        a;
		logic        b;
		logic [2:0]  idx;
		logic [31:0] data;
		logic        typed;
		pid_result_t want;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = MODE_EDGE_A;
	logic               level_a = 1'b0;
	logic               level_b = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [6:0]         duty;
	logic               drive_on;
	logic               stopped;
	logic [23:0]        angle;
	logic signed [31:0] control_value;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = REG_PROP_GAIN;
	logic [31:0]        cfg_data = '0;

	// controller model state
	logic signed [23:0] enc_count = '0;
	longint             err_last = 0;
	longint             err_prev = 0;
	logic signed [31:0] ctrl_acc = '0;
	logic               pid_halted = 1'b0;
	logic signed [15:0] prop_k = '0;
	logic signed [15:0] integ_k = '0;
	logic signed [15:0] deriv_k = '0;
	logic [23:0]        target_q8 = TARGET_ANGLE_RST;
	logic [15:0]        deg_per_cnt = DEG_PER_COUNT_RST;

	pid_result_t pending_results[$];
	plan_row_t   plan_tbl [DIR_ROWS];

	int mismatches = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;

	// encoder pin state for well-formed runs
	logic pin_a = 1'b0;
	logic pin_b = 1'b0;
	logic run_fwd = 1'b1;
	int   run_left = 0;

	quadrature_angle_incremental_pid dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quadrature count step, saturating at the signed bounds
	function automatic void step_encoder(input logic [1:0] m, input logic a, input logic b);
		logic up;
		up = (m == MODE_EDGE_A) ? (a != b) : (a == b);
		if (up && enc_count != COUNT_TOP)
			enc_count = enc_count + 24'sd1;
		else if (!up && enc_count != COUNT_BOTTOM)
			enc_count = enc_count - 24'sd1;
	endfunction

	// |count| * degrees per count, truncated to Q.8 and clipped
	function automatic logic [23:0] angle_of_count();
		longint mag;
		longint prod;
		mag = (enc_count < 0) ? -longint'(enc_count) : longint'(enc_count);
		prod = (mag * longint'(deg_per_cnt)) >>> (16 - FRACTION_BITS_DEF);
		return (prod > longint'(ANGLE_MAX)) ? ANGLE_MAX : prod[23:0];
	endfunction

	// one control tick: incremental pid update, halt latch, duty
	function automatic pid_result_t tick_outcome();
		pid_result_t r;
		longint err;
		longint delta;
		longint acc;
		longint mag;
		longint pct;
		r.angle = angle_of_count();
		if (!pid_halted) begin
			err = longint'(target_q8) - longint'(r.angle);
			delta = longint'(prop_k) * (err - err_last) + longint'(integ_k) * err
				+ longint'(deriv_k) * (err - 2 * err_last + err_prev);
			delta = delta >>> GAIN_FRAC;
			acc = longint'(ctrl_acc) + delta;
			if (acc > ACC_TOP)
				acc = ACC_TOP;
			else if (acc < ACC_BOTTOM)
				acc = ACC_BOTTOM;
			ctrl_acc = acc[31:0];
			err_prev = err_last;
			err_last = err;
			if (r.angle >= target_q8)
				pid_halted = 1'b1;
		end
		mag = (ctrl_acc < 0) ? -longint'(ctrl_acc) : longint'(ctrl_acc);
		pct = mag >>> FRACTION_BITS_DEF;
		if (pct > DUTY_MAX_DEF)
			pct = DUTY_MAX_DEF;
		r.duty = pid_halted ? 7'd0 : pct[6:0];
		r.drive_on = !pid_halted;
		r.stopped = pid_halted;
		r.control = ctrl_acc;
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// offer one input beat, then update the model once it is taken
	task automatic send_item(input logic [1:0] m, input logic a, input logic b,
			input logic typed, input pid_result_t want);
		pid_result_t got;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		level_a <= a;
		level_b <= b;
		do @(posedge clk); while (in_stall);
		if (m == MODE_TICK) begin
			got = tick_outcome();
			pending_results.push_back(typed ? want : got);
		end else if (m != MODE_UNUSED) begin
			step_encoder(m, a, b);
		end
	endtask

	// register write beat
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PROP_GAIN:     prop_k = d[15:0];
			REG_INTEGRAL_GAIN: integ_k = d[15:0];
			REG_DERIV_GAIN:    deriv_k = d[15:0];
			REG_TARGET_ANGLE:  target_q8 = d[23:0];
			REG_DEG_PER_COUNT: deg_per_cnt = d[15:0];
			default: ;
		endcase
	endtask

	// drain all results, then let any trailing edge beat finish
	task automatic settle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_gain(input logic fine);
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return fine ? 16'($urandom_range(1023)) - 16'd512 : 16'($urandom);
		endcase
	endfunction

	// fine phases hold the angle at zero against a small target
	task automatic configure_phase(input logic fine);
		logic [23:0] tgt;
		logic [15:0] dpc;
		if (fine)
			tgt = 24'($urandom_range(4000, 1));
		else if ($urandom_range(3) == 0)
			tgt = 24'hFFFFFF;
		else
			tgt = 24'($urandom_range(24'hFFFFFF, 24'h100000));
		if (fine)
			dpc = 16'h0000;
		else if ($urandom_range(2) == 0)
			dpc = 16'hFFFF;
		else
			dpc = 16'($urandom_range(16'hFFFF, 1));
		write_reg(REG_PROP_GAIN, {16'($urandom), pick_gain(fine)});
		write_reg(REG_INTEGRAL_GAIN, {16'($urandom), pick_gain(fine)});
		write_reg(REG_DERIV_GAIN, {16'($urandom), pick_gain(fine)});
		write_reg(REG_TARGET_ANGLE, {8'($urandom), tgt});
		write_reg(REG_DEG_PER_COUNT, {16'($urandom), dpc});
	endtask

	// mostly clean quadrature runs, some ticks, a little junk
	task automatic run_random(input int n);
		logic [1:0] m;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if (run_left == 0) begin
					run_fwd = 1'($urandom_range(1));
					run_left = $urandom_range(40, 1);
				end
				run_left--;
				if ((pin_a == pin_b) == run_fwd) begin
					pin_a = !pin_a;
					m = MODE_EDGE_A;
				end else begin
					pin_b = !pin_b;
					m = MODE_EDGE_B;
				end
				send_item(m, pin_a, pin_b, 1'b0, '0);
			end else if (pick < 92) begin
				send_item(MODE_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
			end else begin
				send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b0, '0);
			end
		end
	endtask

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_asked != hold_given) begin
			hold_given <= hold_given + 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result beat check
	always @(posedge clk) begin
		pid_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result beat with nothing expected, angle %0d", angle));
			end else begin
				w = pending_results.pop_front();
				if (duty !== w.duty)
					note_failure($sformatf("duty exp %0d got %0d", w.duty, duty));
				if (drive_on !== w.drive_on)
					note_failure($sformatf("drive_on exp %0d got %0d", w.drive_on, drive_on));
				if (stopped !== w.stopped)
					note_failure($sformatf("stopped exp %0d got %0d", w.stopped, stopped));
				if (angle !== w.angle)
					note_failure($sformatf("angle exp %0d got %0d", w.angle, angle));
				if (control_value !== w.control)
					note_failure($sformatf("control_value exp %0d got %0d",
						w.control, control_value));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("quadrature_angle_incremental_pid test failed");
			$finish;
		end
	end

	// main sequence
	initial begin
		plan_tbl = '{
			'{ROW_ITEM, MODE_TICK, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0, 1'b1,
				'{7'd0, 1'b1, 1'b0, 24'd0, 32'sd0}},
			'{ROW_ITEM, MODE_EDGE_A, 1'b0, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_A, 1'b1, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_A, 1'b1, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_A, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_B, 1'b1, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_B, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_B, 1'b0, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_B, 1'b1, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_UNUSED, 1'b1, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_A, 1'b1, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_B, 1'b1, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			// two counts at the reset scale give 54 in Q.8
			'{ROW_ITEM, MODE_TICK, 1'b1, 1'b1, REG_PROP_GAIN, 32'h0, 1'b1,
				'{7'd0, 1'b1, 1'b0, 24'd54, 32'sd0}},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0000_7FFF, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_INTEGRAL_GAIN, 32'hFFFF_8000, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_DERIV_GAIN, 32'h5A5A_7FFF, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_SPARE_5, 32'h0000_0000, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_SPARE_6, 32'hFFFF_FFFF, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_SPARE_7, 32'hFFFF_FFFF, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_TARGET_ANGLE, 32'hFFFF_FFFF, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_DEG_PER_COUNT, 32'h0000_FFFF, 1'b0, '0},
			'{ROW_ITEM, MODE_TICK, 1'b0, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_TICK, 1'b1, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_EDGE_A, 1'b0, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_TICK, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0000_8000, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_INTEGRAL_GAIN, 32'h0000_7FFF, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_DERIV_GAIN, 32'hFFFF_8000, 1'b0, '0},
			'{ROW_CFG, MODE_EDGE_A, 1'b0, 1'b0, REG_DEG_PER_COUNT, 32'h0000_0000, 1'b0, '0},
			'{ROW_ITEM, MODE_TICK, 1'b1, 1'b1, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_UNUSED, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0},
			'{ROW_ITEM, MODE_TICK, 1'b0, 1'b0, REG_PROP_GAIN, 32'h0, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan_tbl[i]) begin
			if (plan_tbl[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan_tbl[i].idx, plan_tbl[i].data);
			end else begin
				send_item(plan_tbl[i].mode, plan_tbl[i].a, plan_tbl[i].b,
					plan_tbl[i].typed, plan_tbl[i].want);
			end
		end

		// random phases: idling pattern by pairs, wide and fine settings alternate
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph / 2)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			configure_phase(1'(ph % 2));
			// long receiver hold-off while ticks keep coming, fills the block
			if (ph == 0) begin
				hold_asked++;
				for (int k = 0; k < 30; k++)
					send_item(MODE_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
						1'b0, '0);
			end
			run_random(PHASE_ITEMS);
		end

		// target of zero: the next tick stops the loop for good
		settle();
		idle_pct = 21;
		stall_pct = 21;
		write_reg(REG_TARGET_ANGLE, 32'hAB00_0000);
		run_random(90);

		settle();
		if (mismatches == 0)
			$display("quadrature_angle_incremental_pid test passed");
		else
			$display("quadrature_angle_incremental_pid test failed");
		$finish;
	end

endmodule
